/* sv/integer_to_padded_ascii_core_assert.svh */
// ---------------------------------------------------------------------------
// Integer formatter assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_PADDED_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_PADDED_ASCII_CORE_ASSERT_SVH

// Same-cycle implication.
`define ITPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/itpa_pkg.sv */
// ---------------------------------------------------------------------------
// Integer formatter package
// Item types, job record passed front to back, codes and the digit table.
// ---------------------------------------------------------------------------
package itpa_pkg;

  localparam int MAX_DIGITS = 32;

  // radix_code values
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // length_mode values
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_H    = 2'd1;
  localparam logic [1:0] LEN_HH   = 2'd2;
  localparam logic [1:0] LEN_L    = 2'd3;

  // field layout
  localparam logic [1:0] ORDER_RIGHT = 2'd0;
  localparam logic [1:0] ORDER_LEFT  = 2'd1;
  localparam logic [1:0] ORDER_ZERO  = 2'd2;

  localparam logic [31:0] MASK_H      = 32'h0000FFFF;
  localparam logic [31:0] MASK_HH     = 32'h000000FF;
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;  // q = (x * R) >> 35

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [31:0] value_in;
    logic        signed_mode;
    logic [1:0]  radix_code;
    logic        uppercase;
    logic [1:0]  length_mode;
    logic [6:0]  min_width;
    logic        align_left;
    logic        pad_zeros;
    logic        force_plus;
    logic        blank_plus;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // One formatted item: digits least significant first.
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digs;
    logic [5:0]                 ndig;
    logic                       upper;
    logic                       has_sign;
    logic [7:0]                 sign_byte;
    logic [6:0]                 pad;
    logic [1:0]                 order;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? 8'h37 : 8'h57;  // 'A' - 10, 'a' - 10
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d};
    end
  endfunction

endpackage

/* sv/integer_to_padded_ascii_core.sv */
// Rates: the front end extracts an item's D digits (1..32) one per cycle from a shared
//   divide-by-radix step and takes no new item until its job is queued; the sequencer
//   loads a job, then gives one character per cycle while the output is not stalled.
// Sustained rate is the slower of the two; the two-entry job queue absorbs the difference.
// Reset: synchronous, active low rst_n; clears front state, queue pointers, busy and out valid.
// ---------------------------------------------------------------------------
// Integer to padded ASCII formatter
// printf-style integer formatting: sign, radix digits, padding, one char per transfer.
// ---------------------------------------------------------------------------
module integer_to_padded_ascii_core #(
  parameter int MAX_FIELD_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output itpa_pkg::out_item_t out_data
);

  `include "integer_to_padded_ascii_core_assert.svh"

  // Front end -> queue: one finished job record per item.
  itpa_pkg::job_t      job_in;
  itpa_pkg::job_t      job_head;
  itpa_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;

  // Front end: transfer an item, negate and mask the magnitude, then peel
  // off digits least significant first until the magnitude reaches zero.
  // Hold the finished job until the queue has room.
  itpa_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .job      (job_in)
  );

  // Decouple digit extraction from character output.
  itpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (job_in),
    .pop       (q_pop),
    .head      (job_head),
    .status    (q_status)
  );

  // Sequencer: lay out sign, padding and digits per the justification mode
  // and advance one character per cycle whenever the output register frees up.
  itpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (job_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ITPA_ASSERT_IMP(a_push_not_full, q_push, !q_status.full, "job pushed into full queue")
  `ITPA_ASSERT_IMP(a_pop_not_empty, q_pop, !q_status.empty, "job popped from empty queue")
  `ITPA_ASSERT_IMP(a_job_digits, q_push, (job_in.ndig != 6'd0) && (job_in.ndig <= 6'd32), "ndig")
  `ITPA_ASSERT_NXT(a_front_busy, in_valid && in_ready, !in_ready, "front end took a second item")

endmodule

/* sv/itpa_front.sv */
// ---------------------------------------------------------------------------
// Integer formatter front end
// Takes an item, forms sign and magnitude, extracts one digit per cycle.
// ---------------------------------------------------------------------------
module itpa_front #(
  parameter int MAX_FIELD_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itpa_pkg::in_item_t  in_data,
  input  itpa_pkg::q_status_t q_status,
  output logic                q_push,
  output itpa_pkg::job_t      job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_DONE = 2'd2;
  localparam logic [6:0] WMAX   = 7'(MAX_FIELD_WIDTH);

  logic [1:0]  state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [5:0]  ndig_r;
  logic [3:0]  digs_r [itpa_pkg::MAX_DIGITS];
  logic [1:0]  radix_r;
  logic        upper_r, has_sign_r;
  logic [7:0]  sign_r;
  logic [6:0]  width_r;
  logic [1:0]  order_r;

  logic        neg;
  logic [31:0] mag_in, mag_masked;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  ten_lo, dig;
  logic [6:0]  body;

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_DONE) && !q_status.full;

  assign neg    = in_data.signed_mode && in_data.value_in[31];
  assign mag_in = neg ? (~in_data.value_in + 32'd1) : in_data.value_in;

  always_comb begin
    case (in_data.length_mode)
      itpa_pkg::LEN_H:  mag_masked = mag_in & itpa_pkg::MASK_H;
      itpa_pkg::LEN_HH: mag_masked = mag_in & itpa_pkg::MASK_HH;
      default:          mag_masked = mag_in;
    endcase
  end

  // Decimal step: reciprocal multiply, remainder from the low nibble only.
  // Upper operand halves are zero, so this is a 32 x 32 product.
  assign prod   = {32'd0, mag_r} * {32'd0, itpa_pkg::DIV10_RECIP};
  assign quot   = {3'b000, prod[63:35]};
  assign ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

  always_comb begin
    case (radix_r)
      itpa_pkg::RADIX_BIN: begin
        dig     = {3'b000, mag_r[0]};
        mag_nxt = {1'b0, mag_r[31:1]};
      end
      itpa_pkg::RADIX_OCT: begin
        dig     = {1'b0, mag_r[2:0]};
        mag_nxt = {3'b000, mag_r[31:3]};
      end
      itpa_pkg::RADIX_DEC: begin
        dig     = mag_r[3:0] - ten_lo;
        mag_nxt = quot;
      end
      default: begin
        dig     = mag_r[3:0];
        mag_nxt = {4'h0, mag_r[31:4]};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_RUN;
      F_RUN:  if (mag_nxt == 32'd0) state_nxt = F_DONE;
      F_DONE: if (!q_status.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag_r      <= mag_masked;
      ndig_r     <= 6'd0;
      radix_r    <= in_data.radix_code;
      upper_r    <= in_data.uppercase;
      width_r    <= (in_data.min_width > WMAX) ? WMAX : in_data.min_width;
      has_sign_r <= neg || in_data.force_plus || in_data.blank_plus;
      sign_r     <= neg ? itpa_pkg::CH_MINUS :
                    (in_data.force_plus ? itpa_pkg::CH_PLUS : itpa_pkg::CH_SPACE);
      order_r    <= in_data.align_left ? itpa_pkg::ORDER_LEFT :
                    (in_data.pad_zeros ? itpa_pkg::ORDER_ZERO : itpa_pkg::ORDER_RIGHT);
    end else if (state_r == F_RUN) begin
      digs_r[ndig_r[4:0]] <= dig;
      ndig_r              <= ndig_r + 6'd1;
      mag_r               <= mag_nxt;
    end
  end

  assign body = {1'b0, ndig_r} + {6'd0, has_sign_r};

  always_comb begin
    for (int i = 0; i < itpa_pkg::MAX_DIGITS; i++) begin
      job.digs[i] = digs_r[i];
    end
    job.ndig      = ndig_r;
    job.upper     = upper_r;
    job.has_sign  = has_sign_r;
    job.sign_byte = sign_r;
    job.pad       = (width_r > body) ? (width_r - body) : 7'd0;
    job.order     = order_r;
  end

endmodule

/* sv/itpa_queue.sv */
// ---------------------------------------------------------------------------
// Integer formatter job queue
// Two-entry queue between front end and character sequencer.
// ---------------------------------------------------------------------------
module itpa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  itpa_pkg::job_t      push_data,
  input  logic                pop,
  output itpa_pkg::job_t      head,
  output itpa_pkg::q_status_t status
);

  itpa_pkg::job_t slot_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

/* sv/itpa_back.sv */
// ---------------------------------------------------------------------------
// Integer formatter character sequencer
// Walks a job's field to an output reg, one char per cycle unless stalled.
// ---------------------------------------------------------------------------
module itpa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itpa_pkg::job_t       head,
  input  itpa_pkg::q_status_t  q_status,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output itpa_pkg::out_item_t  out_data
);

  localparam logic [1:0] SEG_SIGN = 2'd0;
  localparam logic [1:0] SEG_PAD  = 2'd1;
  localparam logic [1:0] SEG_DIG  = 2'd2;

  logic                       busy_r;
  logic [6:0]                 pos_r, b1_r, b2_r, lastpos_r, dend_r;
  logic [1:0]                 k0_r, k1_r, k2_r;
  logic [7:0]                 padc_r, sign_r;
  logic                       upper_r;
  logic [itpa_pkg::MAX_DIGITS-1:0][3:0] digs_r;
  logic                       out_valid_r;
  itpa_pkg::out_item_t        out_data_r;

  logic [6:0] hs, nd, pd, total;
  logic [6:0] b1, b2, dstart;
  logic [1:0] k0, k1, k2;
  logic [7:0] padc;
  logic       advance;
  logic [1:0] kind;
  logic [6:0] didx;
  logic [7:0] ch;

  assign q_pop   = !busy_r && !q_status.empty;
  assign advance = busy_r && (!out_valid_r || out_ready);

  assign hs    = {6'd0, head.has_sign};
  assign nd    = {1'b0, head.ndig};
  assign pd    = head.pad;
  assign total = hs + nd + pd;

  // Segment layout for the job at the head of the queue.
  always_comb begin
    case (head.order)
      itpa_pkg::ORDER_LEFT: begin
        k0 = SEG_SIGN; k1 = SEG_DIG; k2 = SEG_PAD;
        b1 = hs; b2 = hs + nd; dstart = hs; padc = itpa_pkg::CH_SPACE;
      end
      itpa_pkg::ORDER_ZERO: begin
        k0 = SEG_SIGN; k1 = SEG_PAD; k2 = SEG_DIG;
        b1 = hs; b2 = hs + pd; dstart = hs + pd; padc = itpa_pkg::CH_ZERO;
      end
      default: begin
        k0 = SEG_PAD; k1 = SEG_SIGN; k2 = SEG_DIG;
        b1 = pd; b2 = pd + hs; dstart = pd + hs; padc = itpa_pkg::CH_SPACE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pos_r     <= 7'd0;
      b1_r      <= b1;
      b2_r      <= b2;
      k0_r      <= k0;
      k1_r      <= k1;
      k2_r      <= k2;
      padc_r    <= padc;
      sign_r    <= head.sign_byte;
      upper_r   <= head.upper;
      digs_r    <= head.digs;
      lastpos_r <= total - 7'd1;
      dend_r    <= dstart + nd - 7'd1;
    end else if (advance) begin
      pos_r <= pos_r + 7'd1;
    end
  end

  assign kind = (pos_r < b1_r) ? k0_r : ((pos_r < b2_r) ? k1_r : k2_r);
  assign didx = dend_r - pos_r;

  always_comb begin
    case (kind)
      SEG_SIGN: ch = sign_r;
      SEG_PAD:  ch = padc_r;
      default:  ch = itpa_pkg::digit_char(digs_r[didx[4:0]], upper_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (advance && (pos_r == lastpos_r)) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.char_out <= ch;
      out_data_r.last     <= (pos_r == lastpos_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/integer_to_padded_ascii_core_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Integer formatter testbench
// Sends formatted-integer requests through the input channel and checks every
// character on the result channel against a behavioral formatter kept here.
// Covers signs, radices, length masks, padding modes and width saturation.
// ---------------------------------------------------------------------------

// Scoreboard: builds the character stream that one request must produce and
// compares it, in order, with the characters that come out of the block.
class format_scoreboard;
  itpa_pkg::out_item_t pending_chars[$];
  int unsigned         mismatches;
  int unsigned         field_cap;

  function new(int unsigned cap);
    field_cap  = cap;
    mismatches = 0;
  endfunction

  // Note one accepted request: format it and queue its characters.
  function void add_field(itpa_pkg::in_item_t it);
    logic [31:0]         mag;
    logic [7:0]          digs[$];
    logic [7:0]          field[$];
    logic [7:0]          sign_ch;
    logic                neg;
    logic                has_sign;
    int unsigned         base;
    int unsigned         width;
    int unsigned         body;
    int unsigned         pad;
    string               tab;
    itpa_pkg::out_item_t ch;

    width = (it.min_width > field_cap) ? field_cap : it.min_width;
    neg   = it.signed_mode && it.value_in[31];
    mag   = neg ? (~it.value_in + 32'd1) : it.value_in;
    case (it.length_mode)
      itpa_pkg::LEN_H:  mag = mag & itpa_pkg::MASK_H;
      itpa_pkg::LEN_HH: mag = mag & itpa_pkg::MASK_HH;
      default: ;
    endcase
    case (it.radix_code)
      itpa_pkg::RADIX_BIN: base = 2;
      itpa_pkg::RADIX_OCT: base = 8;
      itpa_pkg::RADIX_DEC: base = 10;
      default:             base = 16;
    endcase
    tab = it.uppercase ? "0123456789ABCDEF" : "0123456789abcdef";
    if (mag == 32'd0) begin
      digs.push_back(itpa_pkg::CH_ZERO);
    end
    while (mag != 32'd0) begin
      digs.push_front(tab[mag % base]);
      mag = mag / base;
    end

    has_sign = neg || it.force_plus || it.blank_plus;
    sign_ch  = neg ? itpa_pkg::CH_MINUS :
               (it.force_plus ? itpa_pkg::CH_PLUS : itpa_pkg::CH_SPACE);
    body     = digs.size() + (has_sign ? 1 : 0);
    pad      = (body >= width) ? 0 : width - body;

    // Left justification wins over zero padding.
    if (it.align_left) begin
      if (has_sign) field.push_back(sign_ch);
      foreach (digs[i]) field.push_back(digs[i]);
      repeat (pad) field.push_back(itpa_pkg::CH_SPACE);
    end else if (it.pad_zeros) begin
      if (has_sign) field.push_back(sign_ch);
      repeat (pad) field.push_back(itpa_pkg::CH_ZERO);
      foreach (digs[i]) field.push_back(digs[i]);
    end else begin
      repeat (pad) field.push_back(itpa_pkg::CH_SPACE);
      if (has_sign) field.push_back(sign_ch);
      foreach (digs[i]) field.push_back(digs[i]);
    end

    foreach (field[i]) begin
      ch.char_out = field[i];
      ch.last     = (i == field.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Check one character transfer against the oldest pending character.
  function void check_char(itpa_pkg::out_item_t got);
    itpa_pkg::out_item_t want;

    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected char: expected none, actual 8'h%02h last %0b",
               $time, got.char_out, got.last);
      mismatches++;
      return;
    end
    want = pending_chars.pop_front();
    if (got.char_out !== want.char_out) begin
      $display("%0t: char_out mismatch: expected 8'h%02h actual 8'h%02h",
               $time, want.char_out, got.char_out);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch: expected %0b actual %0b",
               $time, want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module integer_to_padded_ascii_core_test;

  localparam int unsigned FIELD_CAP    = 64;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned CALM_ITEMS   = 60;   // tail of the run without idling
  localparam int unsigned TAIL_CYCLES  = 120;  // worst first-char latency plus a field
  localparam longint      TIMEOUT_NS   = 64'd10_000_000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  itpa_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  itpa_pkg::out_item_t out_data;

  format_scoreboard sb;

  // Idling control shared by both sides: off in some stretches and at the end.
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;

  integer_to_padded_ascii_core #(
    .MAX_FIELD_WIDTH(FIELD_CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run (every field at full width,
  // every character stalled by the longest receiver burst).
  initial begin
    #(TIMEOUT_NS);
    $display("** integer_to_padded_ascii_core: FAILED **");
    $finish;
  end

  // Result side: check each character transfer, then pick next cycle's ready.
  // Stalls come in bursts, started only while idling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) sb.check_char(out_data);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic itpa_pkg::in_item_t make_item(logic [31:0] v, logic sgn,
                                                   logic [1:0] radix, logic up,
                                                   logic [1:0] len, logic [6:0] width,
                                                   logic left, logic zp, logic plus,
                                                   logic spc);
    itpa_pkg::in_item_t it;
    it.value_in    = v;
    it.signed_mode = sgn;
    it.radix_code  = radix;
    it.uppercase   = up;
    it.length_mode = len;
    it.min_width   = width;
    it.align_left  = left;
    it.pad_zeros   = zp;
    it.force_plus  = plus;
    it.blank_plus  = spc;
    return it;
  endfunction

  // Random request: values lean toward edges and mask-to-zero cases,
  // widths lean small with a few at and beyond the cap.
  function automatic itpa_pkg::in_item_t random_item();
    itpa_pkg::in_item_t it;
    int unsigned        pick;

    case ($urandom_range(0, 5))
      0: it.value_in = $urandom;
      1: it.value_in = $urandom_range(0, 20);
      2: begin
        pick = $urandom_range(0, 6);
        case (pick)
          0: it.value_in = 32'h0000_0000;
          1: it.value_in = 32'h8000_0000;
          2: it.value_in = 32'h7FFF_FFFF;
          3: it.value_in = 32'hFFFF_FFFF;
          4: it.value_in = 32'h0001_0000;
          5: it.value_in = 32'h0000_0100;
          default: it.value_in = 32'hFFFF_0000;
        endcase
      end
      3: it.value_in = -$urandom_range(0, 300);
      4: it.value_in = $urandom & ($urandom_range(0, 1) ? 32'hFFFF_0000 : 32'hFFFF_FF00);
      default: it.value_in = $urandom_range(0, 32'hFFFF);
    endcase
    it.signed_mode = 1'($urandom_range(0, 1));
    it.radix_code  = 2'($urandom_range(0, 3));
    it.uppercase   = 1'($urandom_range(0, 1));
    it.length_mode = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 6)      it.min_width = 7'($urandom_range(0, 20));
    else if (pick < 9) it.min_width = 7'($urandom_range(21, 64));
    else               it.min_width = 7'($urandom_range(65, 127));
    it.align_left = 1'($urandom_range(0, 1));
    it.pad_zeros  = 1'($urandom_range(0, 1));
    it.force_plus = 1'($urandom_range(0, 1));
    it.blank_plus = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Drive one request and hold it until the transfer. Valid stays high on
  // return; the caller either sends the next request or calls stop_sending
  // in the same time step.
  task automatic send_item(input itpa_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.add_field(it);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Step the clock, then hold until every queued character is back.
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending_chars.size() != 0);
  endtask

  task automatic run_directed();
    // Zero, plain.
    send_item(make_item(32'd0, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE, 7'd0,
                        1'b0, 1'b0, 1'b0, 1'b0));
    // Most negative signed value.
    send_item(make_item(32'h8000_0000, 1'b1, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Longest digit string: 32 binary ones.
    send_item(make_item(32'hFFFF_FFFF, 1'b0, itpa_pkg::RADIX_BIN, 1'b0, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Minus one; sign rules put '-' ahead of '+'.
    send_item(make_item(32'hFFFF_FFFF, 1'b1, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    // Largest positive signed value, hex upper, forced plus.
    send_item(make_item(32'h7FFF_FFFF, 1'b1, itpa_pkg::RADIX_HEX, 1'b1, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    // Hex case in both modes.
    send_item(make_item(32'hDEAD_BEEF, 1'b0, itpa_pkg::RADIX_HEX, 1'b0, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(32'hDEAD_BEEF, 1'b1, itpa_pkg::RADIX_HEX, 1'b1, itpa_pkg::LEN_L,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(32'h0000_ABCD, 1'b1, itpa_pkg::RADIX_HEX, 1'b1, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Octal full range.
    send_item(make_item(32'hFFFF_FFFF, 1'b0, itpa_pkg::RADIX_OCT, 1'b0, itpa_pkg::LEN_NONE,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Length masks: h clears everything, hh on a negative leaves "-0", hh keeps 255.
    send_item(make_item(32'h1234_0000, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_H,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(-32'sd256, 1'b1, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_HH,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(32'h0000_01FF, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_HH,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(32'hFFFF_8001, 1'b1, itpa_pkg::RADIX_HEX, 1'b0, itpa_pkg::LEN_H,
                        7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Oversized width saturates, right justified.
    send_item(make_item(32'd12345, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd127, 1'b0, 1'b0, 1'b0, 1'b0));
    // Full width, zero padded after the minus.
    send_item(make_item(-32'sd42, 1'b1, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd64, 1'b0, 1'b1, 1'b0, 1'b0));
    // Left justify with zero pad: trailing spaces.
    send_item(make_item(32'd7, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd65, 1'b1, 1'b1, 1'b1, 1'b0));
    // Space sign on an unsigned value.
    send_item(make_item(32'd99, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd6, 1'b0, 1'b0, 1'b0, 1'b1));
    // Width shorter than sign plus digits: no padding.
    send_item(make_item(32'h8000_0000, 1'b1, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd3, 1'b0, 1'b1, 1'b0, 1'b0));
    // Zero pad without a sign.
    send_item(make_item(32'hBEEF, 1'b0, itpa_pkg::RADIX_HEX, 1'b0, itpa_pkg::LEN_NONE,
                        7'd10, 1'b0, 1'b1, 1'b0, 1'b0));
    // Left justify with plus.
    send_item(make_item(32'd5, 1'b1, itpa_pkg::RADIX_OCT, 1'b0, itpa_pkg::LEN_NONE,
                        7'd10, 1'b1, 1'b0, 1'b1, 1'b0));
    // Width equal to the body.
    send_item(make_item(32'd3, 1'b0, itpa_pkg::RADIX_DEC, 1'b0, itpa_pkg::LEN_NONE,
                        7'd1, 1'b0, 1'b0, 1'b0, 1'b0));
    // Binary zero, full width, left.
    send_item(make_item(32'd0, 1'b0, itpa_pkg::RADIX_BIN, 1'b0, itpa_pkg::LEN_NONE,
                        7'd64, 1'b1, 1'b0, 1'b0, 1'b1));
    // Sign plus 32 binary digits inside a full-width field.
    send_item(make_item(32'hFFFF_FFFF, 1'b0, itpa_pkg::RADIX_BIN, 1'b1, itpa_pkg::LEN_L,
                        7'd64, 1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  initial begin
    sb = new(FIELD_CAP);

    // Reset once, at the start.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Hold the sender until the block has emptied.
    stop_sending();
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Toggle idling per stretch of 32; switch it off for the final stretch.
      if (n >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      else if (n % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
      // A second full drain mid-run.
      if (n == RANDOM_ITEMS / 2) begin
        stop_sending();
        wait_drained();
      end
      send_item(random_item());
    end

    stop_sending();
    wait_drained();
    // Catch any stray characters after the last field.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("** integer_to_padded_ascii_core: PASSED **");
    end else begin
      $display("** integer_to_padded_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/itpa_pkg.sv
sv/itpa_front.sv
sv/itpa_queue.sv
sv/itpa_back.sv
sv/integer_to_padded_ascii_core.sv
tb/sv/integer_to_padded_ascii_core_test.sv
